@@ sv/gdr_pkg.sv @@
// Package for the glyph digit renderer: shape codes, work item type, glyph table.
package gdr_pkg;

  localparam int unsigned NUM_DIGITS  = 10;
  localparam int unsigned GRID_CELLS  = 15;
  localparam logic [5:0]  BLOCK_SIZE_RESET = 6'd10;

  typedef enum logic [3:0] {
    SH_EMPTY   = 4'd0,
    SH_FULL    = 4'd1,
    SH_DISC_TL = 4'd2,
    SH_DISC_TR = 4'd3,
    SH_DISC_BR = 4'd4,
    SH_DISC_BL = 4'd5,
    SH_DIAG_TL = 4'd6,
    SH_DIAG_TR = 4'd7,
    SH_DIAG_BR = 4'd8,
    SH_DIAG_BL = 4'd9,
    SH_NOTCH_L = 4'd10,
    SH_NOTCH_R = 4'd11
  } shape_t;

  // One classified pixel request: block shape plus offsets inside the block.
  typedef struct packed {
    shape_t     shape;
    logic [5:0] px;
    logic [5:0] py;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Block shapes, row-major over the 3x5 grid.
  localparam logic [3:0] GLYPH_TABLE [NUM_DIGITS][GRID_CELLS] = '{
    '{4'd2, 4'd1, 4'd3, 4'd1, 4'd0, 4'd1, 4'd1, 4'd0, 4'd1, 4'd1, 4'd0, 4'd1, 4'd5, 4'd1, 4'd4},
    '{4'd0, 4'd1, 4'd0, 4'd1, 4'd1, 4'd0, 4'd0, 4'd1, 4'd0, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1, 4'd1},
    '{4'd2, 4'd1, 4'd3, 4'd0, 4'd0, 4'd1, 4'd6, 4'd1, 4'd8, 4'd1, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1},
    '{4'd2, 4'd1, 4'd3, 4'd0, 4'd0, 4'd1, 4'd0, 4'd1, 4'd11, 4'd0, 4'd0, 4'd1, 4'd5, 4'd1, 4'd4},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd0, 4'd1, 4'd0, 4'd0, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd0, 4'd1, 4'd1, 4'd7, 4'd0, 4'd0, 4'd1, 4'd5, 4'd1, 4'd4},
    '{4'd2, 4'd1, 4'd3, 4'd1, 4'd0, 4'd0, 4'd1, 4'd1, 4'd7, 4'd1, 4'd0, 4'd1, 4'd5, 4'd1, 4'd4},
    '{4'd1, 4'd1, 4'd1, 4'd0, 4'd6, 4'd8, 4'd6, 4'd8, 4'd0, 4'd1, 4'd0, 4'd0, 4'd1, 4'd0, 4'd0},
    '{4'd2, 4'd1, 4'd3, 4'd1, 4'd0, 4'd1, 4'd10, 4'd1, 4'd11, 4'd1, 4'd0, 4'd1, 4'd5, 4'd1, 4'd4},
    '{4'd2, 4'd1, 4'd3, 4'd1, 4'd0, 4'd1, 4'd9, 4'd1, 4'd1, 4'd0, 4'd0, 4'd1, 4'd5, 4'd1, 4'd4}
  };

endpackage

@@ sv/gdr_front.sv @@
// Front end: maps a pixel request to a block shape and in-block offsets.
module gdr_front (
  input  logic [5:0]     block_size,
  input  logic [3:0]     digit_value,
  input  logic [7:0]     pixel_col,
  input  logic [8:0]     pixel_row,
  output gdr_pkg::work_t work
);

  logic [8:0] p1, p2, p3, p4, p5;
  logic [8:0] col9;
  logic       c_ge1, c_ge2, c_ge3;
  logic       r_ge1, r_ge2, r_ge3, r_ge4, r_ge5;
  logic [8:0] col_base, row_base;
  logic [8:0] px_full, py_full;
  logic [1:0] bc;
  logic [2:0] br;
  logic [3:0] grid_idx;
  logic [3:0] digit_idx;
  logic       digit_ok;
  logic       dark;

  // Pitch multiples; pitch is at most 64, so 5*pitch fits in 9 bits.
  assign p1 = {2'b00, 7'(block_size) + 7'd1};
  assign p2 = {p1[7:0], 1'b0};
  assign p3 = p1 + p2;
  assign p4 = {p1[6:0], 2'b00};
  assign p5 = p4 + p1;

  assign col9  = {1'b0, pixel_col};
  assign c_ge1 = col9 >= p1;
  assign c_ge2 = col9 >= p2;
  assign c_ge3 = col9 >= p3;
  assign r_ge1 = pixel_row >= p1;
  assign r_ge2 = pixel_row >= p2;
  assign r_ge3 = pixel_row >= p3;
  assign r_ge4 = pixel_row >= p4;
  assign r_ge5 = pixel_row >= p5;

  always_comb begin
    if (c_ge2) begin
      col_base = p2;
      bc       = 2'd2;
    end else if (c_ge1) begin
      col_base = p1;
      bc       = 2'd1;
    end else begin
      col_base = '0;
      bc       = 2'd0;
    end
    if (r_ge4) begin
      row_base = p4;
      br       = 3'd4;
    end else if (r_ge3) begin
      row_base = p3;
      br       = 3'd3;
    end else if (r_ge2) begin
      row_base = p2;
      br       = 3'd2;
    end else if (r_ge1) begin
      row_base = p1;
      br       = 3'd1;
    end else begin
      row_base = '0;
      br       = 3'd0;
    end
  end

  assign px_full  = col9 - col_base;
  assign py_full  = pixel_row - row_base;
  assign grid_idx = {br, 1'b0} + {1'b0, br} + {2'b00, bc};

  assign digit_ok  = digit_value <= 4'd9;
  assign digit_idx = digit_ok ? digit_value : 4'd0;

  // Offset equal to block_size means the gap line.
  assign dark = !digit_ok || (block_size == 6'd0) || c_ge3 || r_ge5
             || (px_full == {3'b000, block_size}) || (py_full == {3'b000, block_size});

  always_comb begin
    work.px    = px_full[5:0];
    work.py    = py_full[5:0];
    work.shape = dark ? gdr_pkg::SH_EMPTY
                      : gdr_pkg::shape_t'(gdr_pkg::GLYPH_TABLE[digit_idx][grid_idx]);
  end

endmodule

@@ sv/gdr_queue.sv @@
// Two-entry queue of classified requests between front and back end.
module gdr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gdr_pkg::work_t     wdata,
  input  logic               pop,
  output gdr_pkg::work_t     rdata,
  output gdr_pkg::q_stat_t   stat
);

  gdr_pkg::work_t mem [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;
  logic           do_push, do_pop;

  assign stat.full  = count == 2'd2;
  assign stat.empty = count == 2'd0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ sv/gdr_back.sv @@
// Back end: evaluates the block shape and queues the pixel result.
module gdr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [5:0]       block_size,
  input  gdr_pkg::work_t   work,
  input  logic             work_empty,
  output logic             work_pop,
  input  logic             pop,
  output logic             empty,
  output logic             pixel_on
);

  logic [5:0]  s, ix, iy;
  logic [11:0] r;
  logic [11:0] sq_px, sq_py, sq_ix, sq_iy;
  logic [6:0]  pxy;
  logic        lit;
  logic        res_mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        out_full, do_pop;

  assign s     = block_size - 6'd1;
  assign r     = 12'(s * s) + {6'd0, s};
  assign ix    = s - work.px;
  assign iy    = s - work.py;
  assign sq_px = 12'(work.px * work.px);
  assign sq_py = 12'(work.py * work.py);
  assign sq_ix = 12'(ix * ix);
  assign sq_iy = 12'(iy * iy);
  assign pxy   = {1'b0, work.px} + {1'b0, work.py};

  always_comb begin
    case (work.shape)
      gdr_pkg::SH_EMPTY:   lit = 1'b0;
      gdr_pkg::SH_FULL:    lit = 1'b1;
      gdr_pkg::SH_DISC_TL: lit = ({1'b0, sq_ix} + {1'b0, sq_iy}) <= {1'b0, r};
      gdr_pkg::SH_DISC_TR: lit = ({1'b0, sq_px} + {1'b0, sq_iy}) <= {1'b0, r};
      gdr_pkg::SH_DISC_BR: lit = ({1'b0, sq_px} + {1'b0, sq_py}) <= {1'b0, r};
      gdr_pkg::SH_DISC_BL: lit = ({1'b0, sq_ix} + {1'b0, sq_py}) <= {1'b0, r};
      gdr_pkg::SH_DIAG_TL: lit = pxy >= {1'b0, s};
      gdr_pkg::SH_DIAG_TR: lit = work.px <= work.py;
      gdr_pkg::SH_DIAG_BR: lit = pxy < {1'b0, block_size};
      gdr_pkg::SH_DIAG_BL: lit = work.py <= work.px;
      gdr_pkg::SH_NOTCH_L: lit = (pxy >= {1'b0, s}) || (work.py <= work.px);
      gdr_pkg::SH_NOTCH_R: lit = (work.px <= work.py) || (pxy < {1'b0, block_size});
      default:             lit = 1'b1;
    endcase
  end

  // Result queue, two deep so a pop and a new result can share a cycle.
  assign out_full = count == 2'd2;
  assign empty    = count == 2'd0;
  assign work_pop = !work_empty && !out_full;
  assign do_pop   = pop && !empty;
  assign pixel_on = res_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (work_pop) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (work_pop && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !work_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work_pop) begin
      res_mem[wr_ptr] <= lit;
    end
  end

endmodule

@@ sv/block_glyph_digit_pixel_renderer_unit.sv @@
// Top level of the blocky decimal glyph pixel renderer.
//
// Usage:
//   Request side is a queue write port: drive digit_value, pixel_col and
//   pixel_row with push high; the request is taken at an edge where full is low.
//   Result side is a queue read port: while empty is low, pixel_on holds the
//   oldest result; it is consumed at an edge where pop is high.
//   block_size is written through cfg_we/cfg_data (low 6 bits) while the
//   unit is idle; it takes effect for the next request.
// Path: the front end classifies an accepted request into a 2-entry queue, and
//   the back end evaluates its shape into a 2-entry result queue to be popped.
// Throughput: one request per cycle unless the result queue is full, set by the
//   combinational shape evaluator in the back end; push and pop may both fire
//   every cycle.
// Reset (rst, synchronous): both queues empty, block_size returns to 10.
// Stall: if pop stays low the result queue fills, the back end stops draining
//   the request queue, and full rises after at most four requests in flight.
module block_glyph_digit_pixel_renderer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [3:0] digit_value,
  input  logic [7:0] pixel_col,
  input  logic [8:0] pixel_row,
  input  logic       pop,
  output logic       empty,
  output logic       pixel_on,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data
);

  logic             [5:0] block_size;
  gdr_pkg::work_t         front_work;
  gdr_pkg::work_t         q_head;
  gdr_pkg::q_stat_t       q_stat;
  logic                   q_pop;
  logic                   req_accept;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= gdr_pkg::BLOCK_SIZE_RESET;
    end else if (cfg_we) begin
      block_size <= cfg_data;
    end
  end

  assign full       = q_stat.full;
  assign req_accept = push && !q_stat.full;

  gdr_front u_front (
    .block_size  (block_size),
    .digit_value (digit_value),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .work        (front_work)
  );

  gdr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (req_accept),
    .wdata (front_work),
    .pop   (q_pop),
    .rdata (q_head),
    .stat  (q_stat)
  );

  gdr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .block_size (block_size),
    .work       (q_head),
    .work_empty (q_stat.empty),
    .work_pop   (q_pop),
    .pop        (pop),
    .empty      (empty),
    .pixel_on   (pixel_on)
  );

`ifndef NO_ASSERTIONS
  // Request queue only backs up behind a full result queue.
  a_full_implies_result: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("request queue full while result queue empty");

  // A request into an empty unit becomes poppable once it has passed the request queue and the result queue.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_accept && empty && q_stat.empty) |-> ##2 !empty)
    else $error("result missing two cycles after request");

  // Back end drains only a non-empty request queue.
  a_drain_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("back end popped an empty request queue");
`endif

endmodule
